@@ rtl/smb2c_pkg.sv @@
// ----------------------------------------------------------------------------
// SMB2 credit allocator package
// Shared widths, constants, status codes and payload types for the SMB2
// credit charge and message id allocator.
// ----------------------------------------------------------------------------
package smb2c_pkg;

   // Fixed message layout.
   localparam int HEADER_BYTES    = 64;
   localparam int TRANSFORM_BYTES = 52;
   localparam int LEN_BITS        = 24;

   // The charge grows by one credit for each 64 KiB of payload.
   localparam int CHARGE_SHIFT = 16;

   // Field widths.
   localparam int ID_W     = 64;
   localparam int CREDIT_W = 16;
   localparam int NONCE_W  = 64;
   localparam int RLEN_W   = 32;
   localparam int OFFS_W   = 25;
   localparam int STATUS_W = 2;

   // Configuration port.
   localparam int CSR_DATA_W = 64;
   localparam int CSR_ADDR_W = 5;
   localparam int CSR_IDX_LO = 3;

   localparam logic [1:0] CSR_LARGE_MTU      = 2'd0;
   localparam logic [1:0] CSR_CREDIT_CEILING = 2'd1;
   localparam logic [1:0] CSR_NONCE_LIMIT    = 2'd2;
   localparam logic [1:0] CSR_NONCE_BASE     = 2'd3;

   localparam logic [15:0] CREDIT_CEILING_RESET = 16'd8192;

   // Result status codes.
   localparam logic [STATUS_W-1:0] STATUS_OK          = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_IDS_GONE    = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_NO_CREDITS  = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_NONCE_LIMIT = 2'd3;

   typedef struct packed {
      logic                action;
      logic                first_in_compound;
      logic                last_in_compound;
      logic                is_cancel;
      logic                encrypt;
      logic [LEN_BITS-1:0] dyn_len;
      logic [LEN_BITS-1:0] reply_len_max;
      logic [15:0]         min_charge;
      logic [15:0]         fixed_bytes;
      logic [15:0]         granted_credits;
   } req_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [ID_W-1:0]     message_id;
      logic [CREDIT_W-1:0] charge;
      logic [CREDIT_W-1:0] credit_request;
      logic [OFFS_W-1:0]   next_offset;
      logic [RLEN_W-1:0]   compound_length;
      logic [NONCE_W-1:0]  nonce_low_out;
      logic [NONCE_W-1:0]  nonce_high_out;
   } rsp_type;

endpackage

@@ rtl/smb2c_req_if.sv @@
// ----------------------------------------------------------------------------
// SMB2 allocator request channel
// Valid/ready channel carrying one request or credit grant.
// ----------------------------------------------------------------------------
interface smb2c_req_if;
   logic                          valid;
   logic                          ready;
   logic                          action;
   logic                          first_in_compound;
   logic                          last_in_compound;
   logic                          is_cancel;
   logic                          encrypt;
   logic [smb2c_pkg::LEN_BITS-1:0] dyn_len;
   logic [smb2c_pkg::LEN_BITS-1:0] reply_len_max;
   logic [15:0]                   min_charge;
   logic [15:0]                   fixed_bytes;
   logic [15:0]                   granted_credits;

   modport source (
      output valid, action, first_in_compound, last_in_compound, is_cancel, encrypt,
             dyn_len, reply_len_max, min_charge, fixed_bytes, granted_credits,
      input  ready
   );

   modport sink (
      input  valid, action, first_in_compound, last_in_compound, is_cancel, encrypt,
             dyn_len, reply_len_max, min_charge, fixed_bytes, granted_credits,
      output ready
   );
endinterface

@@ rtl/smb2c_rsp_if.sv @@
// ----------------------------------------------------------------------------
// SMB2 allocator result channel
// Valid/ready channel carrying one result per request.
// ----------------------------------------------------------------------------
interface smb2c_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [smb2c_pkg::STATUS_W-1:0] status;
   logic [smb2c_pkg::ID_W-1:0]     message_id;
   logic [smb2c_pkg::CREDIT_W-1:0] charge;
   logic [smb2c_pkg::CREDIT_W-1:0] credit_request;
   logic [smb2c_pkg::OFFS_W-1:0]   next_offset;
   logic [smb2c_pkg::RLEN_W-1:0]   compound_length;
   logic [smb2c_pkg::NONCE_W-1:0]  nonce_low_out;
   logic [smb2c_pkg::NONCE_W-1:0]  nonce_high_out;

   modport source (
      output valid, status, message_id, charge, credit_request, next_offset,
             compound_length, nonce_low_out, nonce_high_out,
      input  ready
   );

   modport sink (
      input  valid, status, message_id, charge, credit_request, next_offset,
             compound_length, nonce_low_out, nonce_high_out,
      output ready
   );
endinterface

@@ rtl/smb2_credit_message_id_allocator_top.sv @@
// ----------------------------------------------------------------------------
// SMB2 credit charge and message id allocator
// Assigns message ids, charges and requests credits, keeps the encryption
// nonce and the running compound length for a stream of SMB2 requests.
// ----------------------------------------------------------------------------
// Usage: each request on req_ch is either one SMB2 request of a compound
// (action 0) or a credit grant from the server (action 1). Every request
// yields exactly one result on rsp_ch, in order.
// The request is captured in an input register; from there the charge,
// the credit checks, the nonce advance and the length sums are worked out in
// one pass and written to the result register, together with the updated
// state, once the result register is free or is being emptied. rsp_ch.valid
// is driven straight from the result register.
// One request is accepted per cycle as long as the result side keeps up; the
// throughput is set by the single state update per request in the compute
// cycle.
// When the receiver stalls, the finished result waits in the result register
// and one further request may still be taken into the input register; after
// that req_ch.ready drops until the result is taken.
// Reset (synchronous, active high) empties both registers, sets the next
// message id, the nonce counters and the running length to zero, the
// available credits to one, the credit ceiling to 8192 and the other registers
// to zero. The APB-style csr port holds large_mtu, the credit ceiling,
// nonce_high_limit and nonce_high_base at byte addresses 0, 8, 16 and 24; it
// should only be written while no request is in flight.
// ----------------------------------------------------------------------------
module smb2_credit_message_id_allocator_top (
   input  logic                                 clock,
   input  logic                                 reset,
   smb2c_req_if.sink                            req_ch,
   smb2c_rsp_if.source                          rsp_ch,
   input  logic                                 csr_psel,
   input  logic                                 csr_penable,
   input  logic                                 csr_pwrite,
   input  logic [smb2c_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  logic [smb2c_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic [smb2c_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output logic                                 csr_pready
);

   localparam int ID_W     = smb2c_pkg::ID_W;
   localparam int CREDIT_W = smb2c_pkg::CREDIT_W;
   localparam int NONCE_W  = smb2c_pkg::NONCE_W;
   localparam int RLEN_W   = smb2c_pkg::RLEN_W;
   localparam int OFFS_W   = smb2c_pkg::OFFS_W;
   localparam int LEN_BITS = smb2c_pkg::LEN_BITS;

   // Configuration registers.
   logic                  large_mtu_ff;
   logic [CREDIT_W-1:0]   credit_ceiling_ff;
   logic [NONCE_W-1:0]    nonce_high_limit_ff;
   logic [NONCE_W-1:0]    nonce_high_base_ff;

   // Allocator state.
   logic [ID_W-1:0]       next_message_id_ff,  next_message_id_in;
   logic [CREDIT_W-1:0]   available_credits_ff, available_credits_in;
   logic [NONCE_W-1:0]    nonce_low_count_ff,  nonce_low_count_in;
   logic [NONCE_W-1:0]    nonce_high_count_ff, nonce_high_count_in;
   logic [RLEN_W-1:0]     running_length_ff,   running_length_in;

   // Input and result registers.
   logic                  in_valid_ff;
   smb2c_pkg::req_type    in_data_ff;
   logic                  out_valid_ff, out_valid_in;
   smb2c_pkg::rsp_type    out_data_ff, out_data_in;

   logic                  step;
   logic                  csr_write;
   logic [1:0]            csr_index;

   // ------------------------------------------------------------------------
   // Handshake. A request in the input register is worked on as soon as the
   // result register is free or is being emptied in the same cycle.
   // ------------------------------------------------------------------------
   assign step         = in_valid_ff && (!out_valid_ff || rsp_ch.ready);
   assign req_ch.ready = !in_valid_ff || step;
   assign out_valid_in = step || (out_valid_ff && !rsp_ch.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= req_ch.valid || (in_valid_ff && !step);
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ch.valid && req_ch.ready) begin
         in_data_ff.action            <= req_ch.action;
         in_data_ff.first_in_compound <= req_ch.first_in_compound;
         in_data_ff.last_in_compound  <= req_ch.last_in_compound;
         in_data_ff.is_cancel         <= req_ch.is_cancel;
         in_data_ff.encrypt           <= req_ch.encrypt;
         in_data_ff.dyn_len           <= req_ch.dyn_len;
         in_data_ff.reply_len_max     <= req_ch.reply_len_max;
         in_data_ff.min_charge        <= req_ch.min_charge;
         in_data_ff.fixed_bytes       <= req_ch.fixed_bytes;
         in_data_ff.granted_credits   <= req_ch.granted_credits;
      end
      if (step) begin
         out_data_ff <= out_data_in;
      end
   end

   assign rsp_ch.valid           = out_valid_ff;
   assign rsp_ch.status          = out_data_ff.status;
   assign rsp_ch.message_id      = out_data_ff.message_id;
   assign rsp_ch.charge          = out_data_ff.charge;
   assign rsp_ch.credit_request  = out_data_ff.credit_request;
   assign rsp_ch.next_offset     = out_data_ff.next_offset;
   assign rsp_ch.compound_length = out_data_ff.compound_length;
   assign rsp_ch.nonce_low_out   = out_data_ff.nonce_low_out;
   assign rsp_ch.nonce_high_out  = out_data_ff.nonce_high_out;

   // ------------------------------------------------------------------------
   // Single-pass computation of one result and the next state.
   // ------------------------------------------------------------------------
   always_comb begin
      logic                  first_enc;
      logic                  nonce_ok;
      logic                  ids_gone;
      logic                  credits_short;
      logic [LEN_BITS-1:0]   len_max;
      logic [LEN_BITS-1:0]   len_max_m1;
      logic [CREDIT_W-1:0]   charge_len;
      logic [CREDIT_W-1:0]   charge;
      logic [CREDIT_W:0]     grant_sum;
      logic [CREDIT_W:0]     credit_diff;
      logic [CREDIT_W-1:0]   credit_req;
      logic [ID_W-1:0]       ids_left;
      logic [NONCE_W-1:0]    nonce_low_adv;
      logic [NONCE_W-1:0]    nonce_high_adv;
      logic [OFFS_W-1:0]     req_len;
      logic [OFFS_W-1:0]     req_len_pad;
      logic [OFFS_W-1:0]     len_add;
      logic [OFFS_W:0]       len_total;
      logic [RLEN_W-1:0]     rlen_base;
      logic [RLEN_W:0]       rlen_sum;
      logic [RLEN_W-1:0]     rlen_new;

      next_message_id_in   = next_message_id_ff;
      available_credits_in = available_credits_ff;
      nonce_low_count_in   = nonce_low_count_ff;
      nonce_high_count_in  = nonce_high_count_ff;
      running_length_in    = running_length_ff;
      out_data_in          = '0;
      out_data_in.status   = smb2c_pkg::STATUS_OK;
      nonce_ok             = 1'b1;

      first_enc = in_data_ff.first_in_compound && in_data_ff.encrypt;

      // Charge: one credit per started 64 KiB of the larger length if large_mtu.
      len_max = (in_data_ff.dyn_len > in_data_ff.reply_len_max) ?
                in_data_ff.dyn_len : in_data_ff.reply_len_max;
      if (len_max == '0) begin
         len_max = LEN_BITS'(1);
      end
      len_max_m1 = len_max - LEN_BITS'(1);
      charge_len = large_mtu_ff ?
                   CREDIT_W'(len_max_m1 >> smb2c_pkg::CHARGE_SHIFT) + CREDIT_W'(1) :
                   CREDIT_W'(1);
      charge = (in_data_ff.min_charge > charge_len) ? in_data_ff.min_charge : charge_len;

      // Message ids left is the distance to all ones; the last id is never used.
      ids_left      = ~next_message_id_ff;
      ids_gone      = (ids_left == '0);
      credits_short = (available_credits_ff < charge) ||
                      ((ids_left[ID_W-1:CREDIT_W] == '0) &&
                       (ids_left[CREDIT_W-1:0] < charge));

      // Credits asked back: ceiling gap plus one, saturated; zero above ceiling.
      credit_diff = {1'b0, credit_ceiling_ff} - {1'b0, available_credits_ff} +
                    (CREDIT_W+1)'(1);
      if (credit_ceiling_ff >= available_credits_ff) begin
         credit_req = credit_diff[CREDIT_W] ? '1 : credit_diff[CREDIT_W-1:0];
      end else begin
         credit_req = '0;
      end

      grant_sum = {1'b0, available_credits_ff} + {1'b0, in_data_ff.granted_credits};

      // Nonce advance; a low counter wrap moves the high counter on.
      if (&nonce_low_count_ff) begin
         nonce_low_adv  = NONCE_W'(1);
         nonce_high_adv = nonce_high_count_ff + NONCE_W'(1);
      end else begin
         nonce_low_adv  = nonce_low_count_ff + NONCE_W'(1);
         nonce_high_adv = nonce_high_count_ff;
      end

      // Request length, padded to 8 bytes unless it closes the compound.
      req_len     = OFFS_W'(smb2c_pkg::HEADER_BYTES) + OFFS_W'(in_data_ff.fixed_bytes) +
                    OFFS_W'(in_data_ff.dyn_len);
      req_len_pad = (req_len + OFFS_W'(7)) & ~OFFS_W'(7);
      len_add     = in_data_ff.last_in_compound ? req_len : req_len_pad;
      len_total   = {1'b0, len_add} +
                    (first_enc ? (OFFS_W+1)'(smb2c_pkg::TRANSFORM_BYTES) : '0);

      rlen_base = in_data_ff.first_in_compound ? '0 : running_length_ff;
      rlen_sum  = {1'b0, rlen_base} + (RLEN_W+1)'(len_total);
      rlen_new  = rlen_sum[RLEN_W] ? '1 : rlen_sum[RLEN_W-1:0];

      if (in_data_ff.action) begin
         // Credit grant.
         available_credits_in        = grant_sum[CREDIT_W] ? '1 : grant_sum[CREDIT_W-1:0];
         out_data_in.compound_length = running_length_ff;
      end else begin
         running_length_in = rlen_base;
         if (first_enc) begin
            nonce_low_count_in  = nonce_low_adv;
            nonce_high_count_in = nonce_high_adv;
            if (nonce_high_adv >= nonce_high_limit_ff) begin
               nonce_ok           = 1'b0;
               out_data_in.status = smb2c_pkg::STATUS_NONCE_LIMIT;
            end
         end
         if (nonce_ok && !in_data_ff.is_cancel) begin
            if (ids_gone) begin
               out_data_in.status = smb2c_pkg::STATUS_IDS_GONE;
            end else if (credits_short) begin
               out_data_in.status = smb2c_pkg::STATUS_NO_CREDITS;
            end else begin
               out_data_in.message_id     = next_message_id_ff;
               out_data_in.charge         = charge;
               out_data_in.credit_request = credit_req;
               next_message_id_in         = next_message_id_ff + ID_W'(charge);
               available_credits_in       = available_credits_ff - charge;
            end
         end
         if (out_data_in.status == smb2c_pkg::STATUS_OK) begin
            running_length_in           = rlen_new;
            out_data_in.compound_length = rlen_new;
            out_data_in.next_offset     = in_data_ff.last_in_compound ? '0 : req_len_pad;
            if (first_enc) begin
               out_data_in.nonce_low_out  = nonce_low_adv;
               out_data_in.nonce_high_out = nonce_high_base_ff + nonce_high_adv;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         next_message_id_ff   <= '0;
         available_credits_ff <= CREDIT_W'(1);
         nonce_low_count_ff   <= '0;
         nonce_high_count_ff  <= '0;
         running_length_ff    <= '0;
      end else if (step) begin
         next_message_id_ff   <= next_message_id_in;
         available_credits_ff <= available_credits_in;
         nonce_low_count_ff   <= nonce_low_count_in;
         nonce_high_count_ff  <= nonce_high_count_in;
         running_length_ff    <= running_length_in;
      end
   end

   // ------------------------------------------------------------------------
   // Configuration port: writes complete in the access cycle, no wait states.
   // ------------------------------------------------------------------------
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;
   assign csr_index  = csr_paddr[smb2c_pkg::CSR_ADDR_W-1:smb2c_pkg::CSR_IDX_LO];
   assign csr_pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         large_mtu_ff        <= 1'b0;
         credit_ceiling_ff   <= smb2c_pkg::CREDIT_CEILING_RESET;
         nonce_high_limit_ff <= '0;
         nonce_high_base_ff  <= '0;
      end else if (csr_write) begin
         case (csr_index)
            smb2c_pkg::CSR_LARGE_MTU: begin
               large_mtu_ff <= csr_pwdata[0];
            end
            smb2c_pkg::CSR_CREDIT_CEILING: begin
               credit_ceiling_ff <= csr_pwdata[CREDIT_W-1:0];
            end
            smb2c_pkg::CSR_NONCE_LIMIT: begin
               nonce_high_limit_ff <= csr_pwdata;
            end
            smb2c_pkg::CSR_NONCE_BASE: begin
               nonce_high_base_ff <= csr_pwdata;
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         smb2c_pkg::CSR_LARGE_MTU:      csr_prdata = smb2c_pkg::CSR_DATA_W'(large_mtu_ff);
         smb2c_pkg::CSR_CREDIT_CEILING: csr_prdata = smb2c_pkg::CSR_DATA_W'(credit_ceiling_ff);
         smb2c_pkg::CSR_NONCE_LIMIT:    csr_prdata = nonce_high_limit_ff;
         smb2c_pkg::CSR_NONCE_BASE:     csr_prdata = nonce_high_base_ff;
         default:                       csr_prdata = '0;
      endcase
   end

endmodule

@@ rtl/smb2c_checker.sv @@
// ----------------------------------------------------------------------------
// SMB2 allocator port checker
// Concurrent assertions on the allocator's result channel, bound to the top.
// ----------------------------------------------------------------------------
module smb2c_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           rsp_valid,
   input logic                           rsp_ready,
   input logic [smb2c_pkg::STATUS_W-1:0] rsp_status,
   input logic [smb2c_pkg::ID_W-1:0]     rsp_message_id,
   input logic [smb2c_pkg::CREDIT_W-1:0] rsp_charge,
   input logic [smb2c_pkg::CREDIT_W-1:0] rsp_credit_request,
   input logic [smb2c_pkg::OFFS_W-1:0]   rsp_next_offset,
   input logic [smb2c_pkg::NONCE_W-1:0]  rsp_nonce_low_out
);

   // No result may appear straight after reset.
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid right after reset");

   // A stalled result holds its status and message id.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) &&
                                  $stable(rsp_message_id))
      else $error("stalled result changed");

   // A failed request carries nothing but its status.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != smb2c_pkg::STATUS_OK) |->
         (rsp_message_id == '0) && (rsp_charge == '0) && (rsp_credit_request == '0) &&
         (rsp_next_offset == '0) && (rsp_nonce_low_out == '0))
      else $error("failed request carries payload");

   // Cancels and grants have no charge, so they get no id and ask no credits.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_charge == '0) |->
         (rsp_message_id == '0) && (rsp_credit_request == '0))
      else $error("uncharged result carries an id or credit request");

endmodule

bind smb2_credit_message_id_allocator_top smb2c_checker u_smb2c_checker (
   .clock              (clock),
   .reset              (reset),
   .rsp_valid          (rsp_ch.valid),
   .rsp_ready          (rsp_ch.ready),
   .rsp_status         (rsp_ch.status),
   .rsp_message_id     (rsp_ch.message_id),
   .rsp_charge         (rsp_ch.charge),
   .rsp_credit_request (rsp_ch.credit_request),
   .rsp_next_offset    (rsp_ch.next_offset),
   .rsp_nonce_low_out  (rsp_ch.nonce_low_out)
);

@@ tb/smb2_credit_message_id_allocator_top_tb.sv @@
// ----------------------------------------------------------------------------
// SMB2 credit allocator testbench
// Drives requests and credit grants into the allocator, predicts every result
// from its own copy of the message id, credit, nonce and length state, and
// checks each result field by field across several register settings and
// idling patterns on both channels.
// ----------------------------------------------------------------------------
module smb2_credit_message_id_allocator_top_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int HOLD_CYCLES    = 300;
   localparam int WATCHDOG_LIMIT = 3000;
   localparam int SETTLE_CYCLES  = 4;
   localparam int REPORT_LIMIT   = 10;

   // -------------------------------------------------------------------------
   // Scoreboard: keeps its own copy of the allocator state and registers,
   // works out the result of every accepted request and compares the results
   // that come back, oldest first.
   // -------------------------------------------------------------------------
   class credit_scoreboard;
      bit          large_mtu;
      bit [15:0]   credit_ceiling;
      bit [63:0]   nonce_limit;
      bit [63:0]   nonce_base;

      bit [63:0]   next_id;
      bit [15:0]   credits;
      bit [63:0]   nonce_lo;
      bit [63:0]   nonce_hi;
      bit [31:0]   run_len;

      smb2c_pkg::rsp_type expected_allocations[$];
      int          mismatches;
      int          grants;
      int          submits;
      int          status_seen[4];

      function new();
         large_mtu      = 1'b0;
         credit_ceiling = smb2c_pkg::CREDIT_CEILING_RESET;
         nonce_limit    = '0;
         nonce_base     = '0;
         next_id        = '0;
         credits        = 16'd1;
         nonce_lo       = '0;
         nonce_hi       = '0;
         run_len        = '0;
      endfunction

      function void set_register(logic [1:0] idx, logic [63:0] value);
         case (idx)
            smb2c_pkg::CSR_LARGE_MTU:      large_mtu      = value[0];
            smb2c_pkg::CSR_CREDIT_CEILING: credit_ceiling = value[15:0];
            smb2c_pkg::CSR_NONCE_LIMIT:    nonce_limit    = value;
            smb2c_pkg::CSR_NONCE_BASE:     nonce_base     = value;
            default: ;
         endcase
      endfunction

      function bit [31:0] sat_add32(bit [31:0] a, bit [63:0] b);
         bit [63:0] s;
         s = {32'd0, a} + b;
         return (s > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : s[31:0];
      endfunction

      function smb2c_pkg::rsp_type predict_allocation(smb2c_pkg::req_type r);
         smb2c_pkg::rsp_type res;
         bit [16:0] sum;
         bit [23:0] widest;
         bit [63:0] ids_left;
         bit [63:0] room;
         bit [63:0] charge;
         bit [63:0] creq;
         bit [63:0] req_len;
         bit [63:0] nlo;
         bit [63:0] nhi;
         res  = '0;
         nlo  = '0;
         nhi  = '0;
         creq = '0;

         if (r.action) begin
            sum     = {1'b0, credits} + {1'b0, r.granted_credits};
            credits = sum[16] ? 16'hFFFF : sum[15:0];
            res.compound_length = run_len;
            return res;
         end

         // The first request of a compound restarts the length; when the
         // compound is encrypted the nonce moves on whether or not the
         // request is later refused.
         if (r.first_in_compound) begin
            run_len = '0;
            if (r.encrypt) begin
               nonce_lo += 64'd1;
               if (nonce_lo == 0) begin
                  nonce_hi += 64'd1;
                  nonce_lo  = 64'd1;
               end
               if (nonce_hi >= nonce_limit) begin
                  res.status = smb2c_pkg::STATUS_NONCE_LIMIT;
                  return res;
               end
               nlo = nonce_lo;
               nhi = nonce_base + nonce_hi;
            end
         end

         if (!r.is_cancel) begin
            ids_left = ~next_id;
            if (ids_left == 0) begin
               res.status = smb2c_pkg::STATUS_IDS_GONE;
               return res;
            end
            if (large_mtu) begin
               widest = 24'd1;
               if (r.dyn_len > widest) widest = r.dyn_len;
               if (r.reply_len_max > widest) widest = r.reply_len_max;
               charge = 64'((widest - 24'd1) >> smb2c_pkg::CHARGE_SHIFT) + 64'd1;
            end else begin
               charge = 64'd1;
            end
            if (64'(r.min_charge) > charge) charge = 64'(r.min_charge);
            room = (64'(credits) < ids_left) ? 64'(credits) : ids_left;
            if (room < charge) begin
               res.status = smb2c_pkg::STATUS_NO_CREDITS;
               return res;
            end
            if (credit_ceiling > credits) creq = 64'(credit_ceiling - credits);
            if (credit_ceiling >= credits) creq += 64'd1;
            if (creq > 64'hFFFF) creq = 64'hFFFF;
            res.message_id     = next_id;
            res.charge         = charge[15:0];
            res.credit_request = creq[15:0];
            next_id += charge;
            credits  = credits - charge[15:0];
         end

         if (r.first_in_compound && r.encrypt)
            run_len = sat_add32(run_len, 64'(smb2c_pkg::TRANSFORM_BYTES));

         req_len = 64'(smb2c_pkg::HEADER_BYTES) + 64'(r.fixed_bytes) + 64'(r.dyn_len);
         if (!r.last_in_compound) begin
            req_len = (req_len + 64'd7) & ~64'd7;
            res.next_offset = req_len[smb2c_pkg::OFFS_W-1:0];
         end
         run_len = sat_add32(run_len, req_len);

         res.status          = smb2c_pkg::STATUS_OK;
         res.compound_length = run_len;
         res.nonce_low_out   = nlo;
         res.nonce_high_out  = nhi;
         return res;
      endfunction

      function void note_request(smb2c_pkg::req_type r);
         smb2c_pkg::rsp_type want;
         want = predict_allocation(r);
         if (r.action) grants++;
         else submits++;
         status_seen[want.status]++;
         expected_allocations.push_back(want);
      endfunction

      function void check_result(smb2c_pkg::rsp_type got);
         smb2c_pkg::rsp_type want;
         string   bad;
         if (expected_allocations.size() == 0) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
               $display("%0t: result with nothing outstanding: %p", $realtime, got);
            return;
         end
         want = expected_allocations.pop_front();
         bad  = "";
         if (got.status          !== want.status)          bad = {bad, " status"};
         if (got.message_id      !== want.message_id)      bad = {bad, " message_id"};
         if (got.charge          !== want.charge)          bad = {bad, " charge"};
         if (got.credit_request  !== want.credit_request)  bad = {bad, " credit_request"};
         if (got.next_offset     !== want.next_offset)     bad = {bad, " next_offset"};
         if (got.compound_length !== want.compound_length) bad = {bad, " compound_length"};
         if (got.nonce_low_out   !== want.nonce_low_out)   bad = {bad, " nonce_low_out"};
         if (got.nonce_high_out  !== want.nonce_high_out)  bad = {bad, " nonce_high_out"};
         if (bad != "") begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT) begin
               $display("%0t: wrong field(s):%s", $realtime, bad);
               $display("   expected %p", want);
               $display("   actual   %p", got);
            end
         end
      endfunction

      function int pending();
         return expected_allocations.size();
      endfunction
   endclass

   // -------------------------------------------------------------------------
   // Clock, channels and the block itself.
   // -------------------------------------------------------------------------
   logic                             clock;
   logic                             reset;
   logic                             csr_psel;
   logic                             csr_penable;
   logic                             csr_pwrite;
   logic [smb2c_pkg::CSR_ADDR_W-1:0] csr_paddr;
   logic [smb2c_pkg::CSR_DATA_W-1:0] csr_pwdata;
   logic [smb2c_pkg::CSR_DATA_W-1:0] csr_prdata;
   logic                             csr_pready;

   smb2c_req_if req_ch ();
   smb2c_rsp_if rsp_ch ();

   smb2_credit_message_id_allocator_top dut (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_ch),
      .rsp_ch      (rsp_ch),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   credit_scoreboard sb = new();

   // Idling rates in percent for the two sides. The main sequence changes
   // them between phases of the run.
   int send_idle_pct;
   int recv_idle_pct;

   // The main sequence bumps hold_asked to make the receiver hold off for a
   // long stretch; the receiver notes it in hold_served once it has begun.
   int hold_asked;
   int hold_served;

   int idle_cycles;
   int requests_sent;

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // -------------------------------------------------------------------------
   // Receiver. Takes results at random with the current idling rate. When a
   // hold-off is asked for, ready is held low while the sender carries on
   // offering requests, so that the result register and the input register
   // both fill and the block lowers ready.
   // -------------------------------------------------------------------------
   initial begin
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_asked != hold_served) begin
            hold_served = hold_asked;
            rsp_ch.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end
         rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // -------------------------------------------------------------------------
   // Monitor and watchdog. Both handshakes are sampled at the rising edge,
   // before any of the nonblocking updates of that edge take effect, so the
   // values seen are the ones the block itself saw. The watchdog counts
   // edges at which nothing moves on either channel or on the register port.
   // -------------------------------------------------------------------------
   always @(posedge clock) begin : monitor
      smb2c_pkg::req_type seen_req;
      smb2c_pkg::rsp_type seen_rsp;
      if (!reset) begin
         if (req_ch.valid && req_ch.ready) begin
            seen_req.action            = req_ch.action;
            seen_req.first_in_compound = req_ch.first_in_compound;
            seen_req.last_in_compound  = req_ch.last_in_compound;
            seen_req.is_cancel         = req_ch.is_cancel;
            seen_req.encrypt           = req_ch.encrypt;
            seen_req.dyn_len           = req_ch.dyn_len;
            seen_req.reply_len_max     = req_ch.reply_len_max;
            seen_req.min_charge        = req_ch.min_charge;
            seen_req.fixed_bytes       = req_ch.fixed_bytes;
            seen_req.granted_credits   = req_ch.granted_credits;
            sb.note_request(seen_req);
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            seen_rsp.status          = rsp_ch.status;
            seen_rsp.message_id      = rsp_ch.message_id;
            seen_rsp.charge          = rsp_ch.charge;
            seen_rsp.credit_request  = rsp_ch.credit_request;
            seen_rsp.next_offset     = rsp_ch.next_offset;
            seen_rsp.compound_length = rsp_ch.compound_length;
            seen_rsp.nonce_low_out   = rsp_ch.nonce_low_out;
            seen_rsp.nonce_high_out  = rsp_ch.nonce_high_out;
            sb.check_result(seen_rsp);
         end
         if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) || csr_psel)
            idle_cycles = 0;
         else
            idle_cycles++;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no progress for %0d cycles, %0d result(s) outstanding",
                     $realtime, WATCHDOG_LIMIT, sb.pending());
            $display("simulation failed");
            $finish;
         end
      end
   end

   // -------------------------------------------------------------------------
   // Driving tasks.
   // -------------------------------------------------------------------------

   // Offers one request, after a random number of idle cycles, and returns
   // at the edge at which the block accepted it. The next call may drive the
   // following request straight away, so valid stays high across requests.
   task automatic send_request(input smb2c_pkg::req_type r);
      while ($urandom_range(99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid             <= 1'b1;
      req_ch.action            <= r.action;
      req_ch.first_in_compound <= r.first_in_compound;
      req_ch.last_in_compound  <= r.last_in_compound;
      req_ch.is_cancel         <= r.is_cancel;
      req_ch.encrypt           <= r.encrypt;
      req_ch.dyn_len           <= r.dyn_len;
      req_ch.reply_len_max     <= r.reply_len_max;
      req_ch.min_charge        <= r.min_charge;
      req_ch.fixed_bytes       <= r.fixed_bytes;
      req_ch.granted_credits   <= r.granted_credits;
      do @(posedge clock); while (!req_ch.ready);
      requests_sent++;
   endtask

   // Stops offering and waits until every expected result has come back,
   // then lets the block settle so that it is truly idle. The first edge
   // lets the monitor note a request accepted at the current edge.
   task automatic wait_drained();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // One register write: a setup cycle, then an access cycle that completes
   // on pready, after which the port is deselected.
   task automatic csr_write(input logic [1:0] idx, input logic [63:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= smb2c_pkg::CSR_ADDR_W'(idx) << smb2c_pkg::CSR_IDX_LO;
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      sb.set_register(idx, value);
      @(posedge clock);
   endtask

   task automatic set_registers(input logic        mtu,
                                input logic [15:0] ceiling,
                                input logic [63:0] limit,
                                input logic [63:0] base);
      csr_write(smb2c_pkg::CSR_LARGE_MTU,      {63'd0, mtu});
      csr_write(smb2c_pkg::CSR_CREDIT_CEILING, {48'd0, ceiling});
      csr_write(smb2c_pkg::CSR_NONCE_LIMIT,    limit);
      csr_write(smb2c_pkg::CSR_NONCE_BASE,     base);
   endtask

   // -------------------------------------------------------------------------
   // Request builders.
   // -------------------------------------------------------------------------
   function automatic smb2c_pkg::req_type make_request(bit first, bit last, bit cancel,
                                                       bit enc, logic [23:0] dyn,
                                                       logic [23:0] maxdyn,
                                                       logic [15:0] minch,
                                                       logic [15:0] fixed);
      smb2c_pkg::req_type r;
      r = '0;
      r.first_in_compound = first;
      r.last_in_compound  = last;
      r.is_cancel         = cancel;
      r.encrypt           = enc;
      r.dyn_len           = dyn;
      r.reply_len_max     = maxdyn;
      r.min_charge        = minch;
      r.fixed_bytes       = fixed;
      return r;
   endfunction

   function automatic smb2c_pkg::req_type make_grant(logic [15:0] amount);
      smb2c_pkg::req_type r;
      r = '0;
      r.action          = 1'b1;
      r.granted_credits = amount;
      return r;
   endfunction

   // Lengths are mostly short, with some near the 64 KiB charge steps and
   // some anywhere in the 24-bit range.
   function automatic logic [23:0] pick_len();
      case ($urandom_range(9))
         0:       return 24'($urandom);
         1:       return 24'($urandom_range(1, 4) * 65536 + $urandom_range(0, 4)) - 24'd2;
         default: return 24'($urandom_range(0, 3000));
      endcase
   endfunction

   function automatic logic [15:0] pick_min_charge();
      case ($urandom_range(9))
         7, 8:    return 16'($urandom_range(0, 400));
         9:       return 16'($urandom);
         default: return 16'($urandom_range(0, 3));
      endcase
   endfunction

   function automatic logic [15:0] pick_fixed();
      return ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 200));
   endfunction

   // Random traffic: mostly well-formed compounds of one to four requests
   // with random content, mixed with credit grants so that the credits keep
   // moving, and a little noise where every field is random. Returns once
   // at least count requests have been accepted.
   task automatic run_traffic(input int count);
      int      sent;
      int      pick;
      int      length;
      smb2c_pkg::req_type r;
      sent = 0;
      while (sent < count) begin
         pick = $urandom_range(99);
         if (pick < 20) begin
            r = make_grant(($urandom_range(9) == 0) ? 16'($urandom)
                                                    : 16'($urandom_range(0, 600)));
            send_request(r);
            sent++;
         end else if (pick < 90) begin
            length = $urandom_range(1, 4);
            for (int i = 0; i < length; i++) begin
               r = make_request(i == 0, i == length - 1, $urandom_range(9) == 0,
                                1'($urandom_range(1)), pick_len(), pick_len(),
                                pick_min_charge(), pick_fixed());
               send_request(r);
               sent++;
            end
         end else begin
            r = $bits(smb2c_pkg::req_type)'({$urandom, $urandom, $urandom, $urandom});
            send_request(r);
            sent++;
         end
      end
   endtask

   // A long run of cancel requests in the middle of a compound, each near the
   // largest length, pushes the running compound length into saturation.
   task automatic run_long_compound(input int count);
      smb2c_pkg::req_type r;
      for (int i = 0; i < count; i++) begin
         r = make_request(1'b0, 1'($urandom_range(1)), 1'b1, 1'($urandom_range(1)),
                          24'hFF0000 | 24'($urandom), 24'($urandom), 16'($urandom),
                          16'($urandom));
         send_request(r);
      end
   endtask

   // -------------------------------------------------------------------------
   // Main sequence.
   // -------------------------------------------------------------------------
   initial begin
      idle_cycles   = 0;
      requests_sent = 0;
      hold_asked    = 0;
      hold_served   = 0;
      send_idle_pct = 15;
      recv_idle_pct = 67;

      reset                    <= 1'b1;
      csr_psel                 <= 1'b0;
      csr_penable              <= 1'b0;
      csr_pwrite               <= 1'b0;
      csr_paddr                <= '0;
      csr_pwdata               <= '0;
      req_ch.valid             <= 1'b0;
      req_ch.action            <= 1'b0;
      req_ch.first_in_compound <= 1'b0;
      req_ch.last_in_compound  <= 1'b0;
      req_ch.is_cancel         <= 1'b0;
      req_ch.encrypt           <= 1'b0;
      req_ch.dyn_len           <= '0;
      req_ch.reply_len_max     <= '0;
      req_ch.min_charge        <= '0;
      req_ch.fixed_bytes       <= '0;
      req_ch.granted_credits   <= '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed requests under the reset settings. The block comes out of
      // reset with a single credit: the first request spends it, the second
      // finds none. Two grants of the full amount show the credit count
      // saturating, and an encrypted first request hits the nonce limit of
      // zero. A cancel with every length at its top pads the next offset,
      // and a request that charges all 65535 credits at once empties the
      // count again.
      send_request(make_request(1'b1, 1'b1, 1'b0, 1'b0, '0, '0, '0, '0));
      send_request(make_request(1'b1, 1'b0, 1'b0, 1'b0, 24'd5, '0, '0, 16'd3));
      send_request(make_grant(16'hFFFF));
      send_request(make_grant(16'hFFFF));
      send_request(make_request(1'b1, 1'b0, 1'b0, 1'b1, '0, '0, '0, '0));
      send_request(make_request(1'b0, 1'b0, 1'b1, 1'b0, 24'hFFFFFF, 24'hFFFFFF,
                                16'hFFFF, 16'hFFFF));
      send_request(make_request(1'b0, 1'b1, 1'b0, 1'b0, '0, '0, 16'hFFFF, 16'd1));
      send_request(make_request(1'b0, 1'b0, 1'b0, 1'b0, 24'd1, 24'd1, '0, 16'd7));
      send_request(make_grant(16'd300));
      wait_drained();

      // Large MTU on with the top credit ceiling, an unreachable nonce limit
      // and an all-ones nonce base. The charge now follows the longer of the
      // two lengths in 64 KiB steps, either side of the first step.
      set_registers(1'b1, 16'hFFFF, '1, '1);
      send_request(make_request(1'b1, 1'b0, 1'b0, 1'b1, 24'hFFFFFF, '0, '0, '0));
      send_request(make_request(1'b0, 1'b0, 1'b0, 1'b0, '0, 24'd65536, '0, '0));
      send_request(make_request(1'b0, 1'b0, 1'b0, 1'b0, '0, 24'd65537, '0, '0));
      send_request(make_request(1'b0, 1'b1, 1'b1, 1'b0, 24'hFFFFFF, 24'hFFFFFF, '0, '0));
      send_request(make_request(1'b1, 1'b1, 1'b0, 1'b1, '0, '0, '0, '0));
      send_request(make_grant(16'd0));
      send_request(make_request(1'b0, 1'b1, 1'b0, 1'b0, '0, '0, '0, '0));
      wait_drained();

      // First phase: the receiver idles far more than the sender. Part way
      // through it holds off for a long stretch so that the block backs up.
      set_registers(1'b0, 16'($urandom), '0, '0);
      run_traffic(250);
      hold_asked++;
      run_traffic(250);
      wait_drained();

      // Second phase: the sender is the slow side. Half way through it stops
      // until every outstanding result has come back.
      send_idle_pct = 67;
      recv_idle_pct = 15;
      set_registers(1'b1, '0, 64'd1, {$urandom, $urandom});
      run_traffic(250);
      wait_drained();
      run_traffic(250);
      wait_drained();

      // Third phase: neither side idles, and a long compound drives the
      // running length to its ceiling.
      send_idle_pct = 0;
      recv_idle_pct = 0;
      set_registers(1'b1, smb2c_pkg::CREDIT_CEILING_RESET, {$urandom, $urandom}, '1);
      run_traffic(200);
      run_long_compound(270);
      run_traffic(230);
      wait_drained();
      repeat (8) @(posedge clock);

      $display("Covered %0d requests and %0d credit grants over five register settings,",
               sb.submits, sb.grants);
      $display("with results ok %0d, out of credits %0d, nonce limit %0d, %0d mismatches.",
               sb.status_seen[smb2c_pkg::STATUS_OK],
               sb.status_seen[smb2c_pkg::STATUS_NO_CREDITS],
               sb.status_seen[smb2c_pkg::STATUS_NONCE_LIMIT], sb.mismatches);
      if (sb.mismatches == 0 && sb.pending() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
